>>> src/rtps_pkg.sv
// Package for the root table pointer scanner: field widths, signature table,
// transfer payload structs and the cell chain structs.
// No dependencies.
package rtps_pkg;

    localparam int ADDR_BITS      = 20;
    localparam int BASE_BITS      = ADDR_BITS - 4;
    localparam int OFF_BITS       = 6;
    localparam int DEFAULT_SLOTS  = 3;

    localparam logic [OFF_BITS-1:0] SIG_LEN    = 6'd8;
    localparam logic [OFF_BITS-1:0] REV_OFFSET = 6'd15;
    localparam logic [OFF_BITS-1:0] SHORT_LEN  = 6'd20;
    localparam logic [OFF_BITS-1:0] LONG_LEN   = 6'd36;
    localparam logic [7:0]          EXT_REV    = 8'd2;

    localparam logic [1:0] VER_NONE  = 2'd0;
    localparam logic [1:0] VER_SHORT = 2'd1;
    localparam logic [1:0] VER_LONG  = 2'd2;

    typedef struct packed {
        logic [7:0]           data_byte;
        logic [ADDR_BITS-1:0] byte_address;
        logic                 start_of_scan;
        logic                 end_of_scan;
    } byte_item_t;

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] table_address;
        logic [1:0]           acpi_version;
    } result_item_t;

    // Common inputs seen by every cell.
    typedef struct packed {
        logic                 accept;
        logic                 scan_en;
        logic                 drop;
        logic [7:0]           data_byte;
        logic [BASE_BITS-1:0] open_base;
    } cell_ctl_t;

    // Best completed candidate, handed along the chain.
    typedef struct packed {
        logic                 hit;
        logic [OFF_BITS-1:0]  offset;
        logic [BASE_BITS-1:0] base;
        logic                 extended;
    } win_t;

    // "RSD PTR "
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h52;
            3'd1:    b = 8'h53;
            3'd2:    b = 8'h44;
            3'd3:    b = 8'h20;
            3'd4:    b = 8'h50;
            3'd5:    b = 8'h54;
            3'd6:    b = 8'h52;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

endpackage

>>> src/rtps_cell.sv
// One candidate slot of the scanner chain: signature check, running sum,
// length tracking, free-slot claim and winner selection passed to the neighbor.
// Depends on rtps_pkg.
module rtps_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rtps_pkg::cell_ctl_t ctl,
    input  logic               flush,
    input  logic               claim_in,
    output logic               claim_out,
    input  rtps_pkg::win_t     win_in,
    output rtps_pkg::win_t     win_out
);
    import rtps_pkg::*;

    logic                 active_reg, active_next;
    logic [BASE_BITS-1:0] base_reg, base_next;
    logic [OFF_BITS-1:0]  offset_reg, offset_next;
    logic [7:0]           sum_reg, sum_next;
    logic                 ext_reg, ext_next;

    logic                 live;
    logic                 sig_ok;
    logic [7:0]           fed_sum;
    logic                 fed_ext;
    logic [OFF_BITS-1:0]  fed_off;
    logic                 fed_done;
    logic                 fed_active;
    logic                 hit;
    logic                 take;

    always_comb
    begin
        live     = active_reg && !ctl.drop && ctl.scan_en;
        sig_ok   = (offset_reg >= SIG_LEN) || (ctl.data_byte == sig_byte(offset_reg[2:0]));
        fed_sum  = sum_reg + ctl.data_byte;
        fed_ext  = (offset_reg == REV_OFFSET) ? (ctl.data_byte == EXT_REV) : ext_reg;
        fed_off  = offset_reg + 6'd1;
        fed_done = fed_off >= (fed_ext ? LONG_LEN : SHORT_LEN);
        fed_active = live && sig_ok && !fed_done;
        hit      = live && sig_ok && fed_done && (fed_sum == 8'd0);

        take      = claim_in && ctl.scan_en && !fed_active;
        claim_out = claim_in && !take;

        if (hit && (!win_in.hit || offset_reg > win_in.offset))
        begin
            win_out.hit      = 1'b1;
            win_out.offset   = offset_reg;
            win_out.base     = base_reg;
            win_out.extended = fed_ext;
        end
        else
        begin
            win_out = win_in;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        base_next   = base_reg;
        offset_next = offset_reg;
        sum_next    = sum_reg;
        ext_next    = ext_reg;
        if (ctl.accept)
        begin
            if (take)
            begin
                active_next = (ctl.data_byte == sig_byte(3'd0));
                base_next   = ctl.open_base;
                offset_next = 6'd1;
                sum_next    = ctl.data_byte;
                ext_next    = 1'b0;
            end
            else
            begin
                active_next = fed_active;
                if (live)
                begin
                    offset_next = fed_off;
                    sum_next    = fed_sum;
                    ext_next    = fed_ext;
                end
            end
            if (flush || (!ctl.scan_en && ctl.drop))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        offset_reg <= offset_next;
        sum_reg    <= sum_next;
        ext_reg    <= ext_next;
    end

endmodule

>>> src/root_table_pointer_scanner.sv
// Top level of the root table pointer scanner: input transfer control, scan
// state, the row of candidate cells and a two-entry result queue.
// Depends on rtps_pkg and rtps_cell.
//
// Usage: the feeder sends one memory byte per transfer on the byte channel
// (byte_valid / byte_stall / byte_item) with its address and scan markers.
// Every 16-byte-aligned byte opens a candidate in a free cell; candidates that
// spell "RSD PTR " and checksum to zero over 20 or 36 bytes complete.
// The first completed candidate (lowest address on ties) gives one result
// transfer on the result channel (result_valid / result_stall / result_item);
// a scan marked ended without a match gives one not-found result.
// Throughput: one byte per cycle while byte_stall is low; all cells update in
// parallel in the same cycle, so the cell chain itself never holds a byte.
// Latency: with the queue empty, a result shows on the cycle after its byte.
// The result queue holds two entries; byte_stall rises only when both are
// full, so bytes keep flowing while one result waits on a stalled receiver.
// Reset clears all candidates, the done flag, the previous address and the
// queue; the first scan needs no start marker.
module root_table_pointer_scanner #(
    parameter int CANDIDATE_SLOTS = rtps_pkg::DEFAULT_SLOTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  rtps_pkg::byte_item_t  byte_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rtps_pkg::result_item_t result_item
);
    import rtps_pkg::*;

    logic                 finished_reg, finished_next;
    logic [ADDR_BITS-1:0] prev_addr_reg, prev_addr_next;
    logic                 head_valid_reg, head_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    result_item_t         head_reg, head_next;
    result_item_t         skid_reg, skid_next;

    logic                 accept;
    logic                 flush;
    logic                 push;
    logic                 pop;
    result_item_t         new_result;
    cell_ctl_t            ctl;
    logic                 claim [CANDIDATE_SLOTS+1];
    win_t                 win   [CANDIDATE_SLOTS+1];

    assign byte_stall   = skid_valid_reg;
    assign accept       = byte_valid && !byte_stall;
    assign result_valid = head_valid_reg;
    assign result_item  = head_reg;
    assign pop          = head_valid_reg && !result_stall;

    always_comb
    begin
        ctl.accept    = accept;
        ctl.scan_en   = byte_item.start_of_scan || !finished_reg;
        ctl.drop      = byte_item.start_of_scan ||
                        (byte_item.byte_address != (prev_addr_reg + ADDR_BITS'(1)));
        ctl.data_byte = byte_item.data_byte;
        ctl.open_base = byte_item.byte_address[ADDR_BITS-1:4];
    end

    assign flush = ctl.scan_en && (win[CANDIDATE_SLOTS].hit || byte_item.end_of_scan);

    assign claim[0] = (byte_item.byte_address[3:0] == 4'd0);
    assign win[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < CANDIDATE_SLOTS; g++)
        begin : g_cell
            rtps_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .flush     (flush),
                .claim_in  (claim[g]),
                .claim_out (claim[g+1]),
                .win_in    (win[g]),
                .win_out   (win[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        push = accept && flush;
        new_result.found = win[CANDIDATE_SLOTS].hit;
        if (win[CANDIDATE_SLOTS].hit)
        begin
            new_result.table_address = {win[CANDIDATE_SLOTS].base, 4'd0};
            new_result.acpi_version  = win[CANDIDATE_SLOTS].extended ? VER_LONG : VER_SHORT;
        end
        else
        begin
            new_result.table_address = '0;
            new_result.acpi_version  = VER_NONE;
        end

        finished_next  = finished_reg;
        prev_addr_next = prev_addr_reg;
        if (accept)
        begin
            prev_addr_next = byte_item.byte_address;
            if (flush)
            begin
                finished_next = 1'b1;
            end
            else if (byte_item.start_of_scan)
            begin
                finished_next = 1'b0;
            end
        end

        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_next       = new_result;
                skid_valid_next = push;
            end
            else
            begin
                head_next       = new_result;
                head_valid_next = push;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_next       = new_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finished_reg   <= 1'b0;
            prev_addr_reg  <= '0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            finished_reg   <= finished_next;
            prev_addr_reg  <= prev_addr_next;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

>>> verif/tb_root_table_pointer_scanner.sv
`timescale 1ns / 100ps
// Testbench for root_table_pointer_scanner: a directed and a random byte stream with
// planted pointer structures, checked against a predictor of the scan.
// Depends on rtps_pkg and the scanner RTL.
module tb_root_table_pointer_scanner;

    localparam int SIG_BYTES   = 8;
    localparam int REV_POS     = 15;
    localparam int SHORT_SIZE  = 20;
    localparam int LONG_SIZE   = 36;
    localparam int SLOTS       = 3;
    localparam logic [63:0] SIGNATURE = "RSD PTR ";

    localparam int ITEM_TARGET  = 750;
    localparam int SCAN_TARGET  = 24;
    localparam int BURST_SCANS  = 30;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 650;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 100000;

    typedef enum int {
        PLANT_SHORT,
        PLANT_LONG,
        PLANT_BAD_SUM,
        PLANT_BAD_SIG,
        PLANT_TIE
    } plant_kind_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_stall;
    rtps_pkg::byte_item_t byte_item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    rtps_pkg::result_item_t result_item;

    rtps_pkg::byte_item_t pending_bytes[$];
    rtps_pkg::result_item_t expected_results[$];
    logic [7:0] scan_image[0:127];

    // predictor state
    logic        cand_live[SLOTS];
    logic [15:0] cand_base[SLOTS];
    logic [5:0]  cand_taken[SLOTS];
    logic [7:0]  cand_sum[SLOTS];
    logic        cand_long[SLOTS];
    logic        scan_done;
    logic [19:0] last_address;

    int cycle_count;
    int bytes_accepted;
    int total_items;
    int pressure_at;
    int hold_left;
    bit hold_done;
    int fail_count = 0;
    int found_count = 0;
    int miss_count = 0;
    int scan_count = 0;
    int input_held_cycles = 0;

    root_table_pointer_scanner u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] sig_char(int i);
        return SIGNATURE[8*(7-i) +: 8];
    endfunction

    function automatic bit roll_idle();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 21;
    endfunction

    function automatic logic [7:0] other_revision();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if (r == 8'd2)
            r = 8'd3;
        return r;
    endfunction

    function automatic void drop_candidates();
        for (int s = 0; s < SLOTS; s++)
            cand_live[s] = 1'b0;
    endfunction

    // returns 1 when the candidate completes with a zero checksum
    function automatic bit cand_take_byte(int s, logic [7:0] b);
        logic [5:0] taken;
        int span;
        taken = cand_taken[s];
        if (int'(taken) < SIG_BYTES && b != sig_char(int'(taken)))
        begin
            cand_live[s] = 1'b0;
            return 1'b0;
        end
        cand_sum[s] = cand_sum[s] + b;
        if (int'(taken) == REV_POS)
            cand_long[s] = (b == 8'd2);
        taken = taken + 6'd1;
        cand_taken[s] = taken;
        span = cand_long[s] ? LONG_SIZE : SHORT_SIZE;
        if (int'(taken) >= span)
        begin
            cand_live[s] = 1'b0;
            return cand_sum[s] == 8'd0;
        end
        return 1'b0;
    endfunction

    task automatic predict_byte(rtps_pkg::byte_item_t it);
        logic [19:0] next_address;
        int win;
        logic [5:0] win_taken;
        logic [5:0] prior;
        bit opened;
        rtps_pkg::result_item_t r;
        next_address = last_address + 20'd1;
        if (it.start_of_scan)
        begin
            drop_candidates();
            scan_done = 1'b0;
        end
        else if (it.byte_address != next_address)
        begin
            drop_candidates();
        end
        last_address = it.byte_address;
        if (scan_done)
            return;
        win = -1;
        win_taken = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (cand_live[s])
            begin
                prior = cand_taken[s];
                if (cand_take_byte(s, it.data_byte) && (win < 0 || prior > win_taken))
                begin
                    win = s;
                    win_taken = prior;
                end
            end
        end
        if (it.byte_address[3:0] == 4'd0)
        begin
            opened = 1'b0;
            for (int s = 0; s < SLOTS; s++)
            begin
                if (!opened && !cand_live[s])
                begin
                    cand_live[s] = 1'b1;
                    cand_base[s] = it.byte_address[19:4];
                    cand_taken[s] = '0;
                    cand_sum[s] = '0;
                    cand_long[s] = 1'b0;
                    void'(cand_take_byte(s, it.data_byte));
                    opened = 1'b1;
                end
            end
        end
        if (win >= 0)
        begin
            r.found = 1'b1;
            r.table_address = {cand_base[win], 4'h0};
            r.acpi_version = cand_long[win] ? rtps_pkg::VER_LONG : rtps_pkg::VER_SHORT;
            expected_results.push_back(r);
            found_count++;
            scan_done = 1'b1;
            drop_candidates();
        end
        else if (it.end_of_scan)
        begin
            r.found = 1'b0;
            r.table_address = '0;
            r.acpi_version = rtps_pkg::VER_NONE;
            expected_results.push_back(r);
            miss_count++;
            scan_done = 1'b1;
            drop_candidates();
        end
    endtask

    task automatic check_result(rtps_pkg::result_item_t got);
        rtps_pkg::result_item_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: found=%0d table_address=%05h acpi_version=%0d",
                   got.found, got.table_address, got.acpi_version);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.found !== want.found)
        begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            fail_count++;
        end
        if (got.table_address !== want.table_address)
        begin
            $error("table_address: expected %05h, actual %05h",
                   want.table_address, got.table_address);
            fail_count++;
        end
        if (got.acpi_version !== want.acpi_version)
        begin
            $error("acpi_version: expected %0d, actual %0d", want.acpi_version, got.acpi_version);
            fail_count++;
        end
    endtask

    task automatic queue_byte(logic [7:0] b, logic [19:0] addr, bit first, bit final_byte);
        rtps_pkg::byte_item_t it;
        it.data_byte = b;
        it.byte_address = addr;
        it.start_of_scan = first;
        it.end_of_scan = final_byte;
        pending_bytes.push_back(it);
    endtask

    task automatic seal_checksum(int off, int span);
        logic [7:0] acc;
        acc = '0;
        scan_image[off+8] = '0;
        for (int i = 0; i < span; i++)
            acc = acc + scan_image[off+i];
        scan_image[off+8] = -acc;
    endtask

    task automatic place_table(int off, bit long_form, bit good_sum);
        int span;
        span = long_form ? LONG_SIZE : SHORT_SIZE;
        for (int i = 0; i < span; i++)
            scan_image[off+i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < SIG_BYTES; i++)
            scan_image[off+i] = sig_char(i);
        scan_image[off+REV_POS] = long_form ? 8'd2 : other_revision();
        seal_checksum(off, span);
        if (!good_sum)
            scan_image[off+8] = scan_image[off+8] + 8'($urandom_range(1, 255));
    endtask

    task automatic queue_scan(logic [19:0] base, int count, bit with_start, bit with_end,
                              int gap_at);
        logic [19:0] addr;
        addr = base;
        for (int i = 0; i < count; i++)
        begin
            queue_byte(scan_image[i], addr, with_start && i == 0, with_end && i == count - 1);
            addr = addr + 20'd1;
            if (i + 1 == gap_at)
                addr = addr + 20'($urandom_range(1, 4000));
        end
    endtask

    task automatic build_stimulus();
        logic [19:0] base;
        int span;
        int first_aligned;
        int plants;
        int off;
        plant_kind_e kind;
        // first scan without a start marker, then the address extremes
        queue_byte(8'h00, 20'h00000, 1'b0, 1'b1);
        queue_byte(8'hFF, 20'hFFFFF, 1'b1, 1'b1);
        // short structure wrapping the top of memory, matched on the final byte
        place_table(0, 1'b0, 1'b1);
        queue_scan(20'hFFFF0, SHORT_SIZE, 1'b1, 1'b1, -1);
        // ignored after the match, end marker included
        queue_byte(8'h52, 20'h00004, 1'b0, 1'b1);

        pressure_at = -1;
        while (pending_bytes.size() < ITEM_TARGET || scan_count < SCAN_TARGET)
        begin
            if (pressure_at < 0 && pending_bytes.size() >= ITEM_TARGET / 2)
            begin
                pressure_at = pending_bytes.size();
                repeat (BURST_SCANS)
                    queue_byte(8'($urandom_range(0, 255)), 20'($urandom_range(0, 20'hFFFFF)),
                               1'b1, 1'b1);
            end
            base = 20'($urandom_range(0, 20'hFFFFF));
            if ($urandom_range(0, 3) != 0)
                base[3:0] = 4'd0;
            if ($urandom_range(0, 9) == 0)
                base = 20'hFFFF0 - 20'(16 * $urandom_range(0, 3));
            span = $urandom_range(8, 64);
            for (int i = 0; i < 128; i++)
                scan_image[i] = 8'($urandom_range(0, 255));
            first_aligned = (16 - int'(base[3:0])) & 15;
            plants = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 2) : 0;
            repeat (plants)
            begin
                off = first_aligned + 16 * $urandom_range(0, 2);
                kind = plant_kind_e'($urandom_range(0, 4));
                case (kind)
                    PLANT_SHORT:   place_table(off, 1'b0, 1'b1);
                    PLANT_LONG:    place_table(off, 1'b1, 1'b1);
                    PLANT_BAD_SUM: place_table(off, 1'($urandom_range(0, 1)), 1'b0);
                    PLANT_BAD_SIG:
                    begin
                        place_table(off, 1'($urandom_range(0, 1)), 1'b1);
                        scan_image[off + $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
                    end
                    default:
                    begin
                        // long candidate and a short one inside it end on the same byte
                        place_table(off, 1'b1, 1'b1);
                        place_table(off + 16, 1'b0, 1'b1);
                        seal_checksum(off, LONG_SIZE);
                    end
                endcase
            end
            queue_scan(base, span, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(1, span - 1) : -1);
            scan_count++;
        end
        total_items = pending_bytes.size();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // byte side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item <= '0;
            bytes_accepted <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                predict_byte(byte_item);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (byte_valid && byte_stall)
                input_held_cycles++;
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 && (hold_left != 0 || !roll_idle()))
                begin
                    byte_item <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // result side monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result_item);
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else if (!hold_done && pressure_at >= 0 && bytes_accepted >= pressure_at)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= roll_idle();
        end
    end

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            cand_live[s] = 1'b0;
            cand_base[s] = '0;
            cand_taken[s] = '0;
            cand_sum[s] = '0;
            cand_long[s] = 1'b0;
        end
        scan_done = 1'b0;
        last_address = '0;
        build_stimulus();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (bytes_accepted != total_items)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d byte transfers in %0d random scans: %0d found, %0d not found",
                 total_items, scan_count, found_count, miss_count);
        $display("byte input held off for %0d cycles by the scanner", input_held_cycles);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
